// File: sv/sfc_pkg.sv
package sfc_pkg;

    localparam int SAMPLES_PER_AXIS = 4;
    localparam int COUNTER_BITS     = 12;
    localparam int NSAMP            = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;

    // exact sample grid: edge coordinates scaled by 2*SAMPLES_PER_AXIS
    localparam int SCALE      = 2 * SAMPLES_PER_AXIS;
    localparam int SCALE_BITS = $clog2(SCALE);
    localparam int PIX_UNIT   = 16 * SCALE;
    localparam int HALF_STEP  = 16;
    localparam int GRID_STEP  = 2 * HALF_STEP;

    // coordinate, difference and cross product widths
    localparam int CW = 17 + SCALE_BITS;
    localparam int DW = CW + 1;
    localparam int XW = 2 * DW + 2;

    localparam int MASK_W    = 16;
    localparam int MASK_KEEP = (NSAMP < MASK_W) ? NSAMP : MASK_W;
    localparam int COUNT_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic signed [COUNTER_BITS-1:0] CNT_MAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam logic signed [COUNTER_BITS-1:0] CNT_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};
    localparam logic signed [COUNTER_BITS-1:0] CNT_ZERO = '0;

    localparam logic signed [CW-1:0] SCALE_S    = CW'(SCALE);
    localparam logic signed [CW-1:0] PIX_UNIT_S = CW'(PIX_UNIT);
    localparam logic signed [CW-1:0] HALF_S     = CW'(HALF_STEP);
    localparam logic signed [CW-1:0] GRID_S     = CW'(GRID_STEP);

    localparam logic signed [XW-1:0] STEP_X_S = XW'(GRID_STEP);
    localparam logic signed [XW-1:0] WRAP_X_S = XW'(GRID_STEP * (SAMPLES_PER_AXIS - 1));

    typedef struct packed {
        logic        [10:0] pixel_x;
        logic        [10:0] pixel_y;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               first_edge;
        logic               last_edge;
    } edge_t;

    typedef struct packed {
        logic [MASK_W-1:0]  inside_mask;
        logic [COUNT_W-1:0] covered_count;
    } result_t;

    // request travelling down the row of sample cells
    typedef struct packed {
        logic                first;
        logic                last;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] sy;
        logic signed [XW-1:0] xprod;
        logic signed [XW-1:0] step_col;
        logic signed [XW-1:0] step_wrap;
        logic [NSAMP-1:0]     mask;
        logic [COUNT_W-1:0]   count;
    } token_t;

    function automatic logic signed [CW-1:0] scale_coord(input logic signed [15:0] v);
        logic signed [CW-1:0] ext;
        ext = CW'(v);
        return ext * SCALE_S;
    endfunction

    function automatic logic signed [CW-1:0] first_sample(input logic [10:0] p);
        logic signed [CW-1:0] ext;
        ext = signed'(CW'(p));
        return ext * PIX_UNIT_S + HALF_S;
    endfunction

endpackage

// File: sv/supersampled_fill_coverage.sv
// channel  | signals                              | moves
// ---------+--------------------------------------+-----------------------------------
// edge     | edge_valid, edge_ready, edge_req     | one edge request per handshake
// result   | result_valid, result_ready, result   | mask and count after a last edge
// cfg      | cfg_valid, cfg_ready, cfg_data       | fill rule write, 0 even-odd 1 nonzero
//
// one edge request per cycle while the output register can take a result; result_valid
// rises once its last request has passed three setup stages, one sample cell per sample
// and one output register (the first setup stage loads at the clock edge that takes it)
// the whole pipeline holds when the output register is full and not taken
// reset clears all winding counters and parity bits and sets the nonzero rule
// cfg is always ready; the user must write it only while no request is in flight (not enforced)
module supersampled_fill_coverage
    import sfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    edge_valid,
    output logic    edge_ready,
    input  edge_t   edge_req,

    output logic    result_valid,
    input  logic    result_ready,
    output result_t result,

    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    logic    fill_rule_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;
    logic    adv;

    // request chain: setup stages feed the row of sample cells
    logic   tok_valid [0:NSAMP];
    token_t tok       [0:NSAMP];

    // whole pipeline advances while the output register can take a result
    assign adv        = !result_valid_reg || result_ready;
    assign edge_ready = adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_rule_reg <= 1'b1;
        else if (cfg_valid)
            fill_rule_reg <= cfg_data;
    end

    // scaled coordinates, cross product at the first sample, per-sample steps
    sfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .edge_valid (edge_valid),
        .edge_req   (edge_req),
        .tok_valid  (tok_valid[0]),
        .tok        (tok[0])
    );

    // one cell per sample, row-major; the last cell of a row wraps to the next row
    for (genvar k = 0; k < NSAMP; k++)
    begin : g_cell
        sfc_cell u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .fill_rule     (fill_rule_reg),
            .col_wrap      ((k % SAMPLES_PER_AXIS) == (SAMPLES_PER_AXIS - 1)),
            .tok_in_valid  (tok_valid[k]),
            .tok_in        (tok[k]),
            .tok_out_valid (tok_valid[k+1]),
            .tok_out       (tok[k+1])
        );
    end

    // only a request marked last leaves a result; mask arrives with sample 0 in bit 0
    always_comb
    begin
        result_valid_next         = result_valid_reg && !result_ready;
        result_next               = result_reg;
        if (adv)
        begin
            result_valid_next = tok_valid[NSAMP] && tok[NSAMP].last;
            result_next.inside_mask   = MASK_W'(tok[NSAMP].mask[MASK_KEEP-1:0]);
            result_next.covered_count = tok[NSAMP].count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/sfc_front.sv
module sfc_front
    import sfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   edge_valid,
    input  edge_t  edge_req,
    output logic   tok_valid,
    output token_t tok
);

    // stage 1: scaled coordinates and differences
    logic                 s1_valid_reg;
    logic                 s1_first_reg, s1_last_reg;
    logic signed [CW-1:0] s1_ay_reg, s1_by_reg, s1_sy_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_rx_reg, s1_ry_reg;

    // stage 2: products
    logic                   s2_valid_reg;
    logic                   s2_first_reg, s2_last_reg;
    logic signed [CW-1:0]   s2_ay_reg, s2_by_reg, s2_sy_reg;
    logic signed [DW-1:0]   s2_dx_reg, s2_dy_reg;
    logic signed [2*DW-1:0] s2_p1_reg, s2_p2_reg;

    logic                   tok_valid_reg;
    token_t                 tok_reg;

    logic signed [CW-1:0]   ax_s, ay_s, bx_s, by_s, sx0_s, sy0_s;
    logic signed [2*DW-1:0] p1_next, p2_next;
    logic signed [XW-1:0]   dx_w, dy_w;
    token_t                 tok_next;

    always_comb
    begin
        ax_s  = scale_coord(edge_req.start_x);
        ay_s  = scale_coord(edge_req.start_y);
        bx_s  = scale_coord(edge_req.end_x);
        by_s  = scale_coord(edge_req.end_y);
        sx0_s = first_sample(edge_req.pixel_x);
        sy0_s = first_sample(edge_req.pixel_y);
    end

    assign p1_next = s1_dx_reg * s1_ry_reg;
    assign p2_next = s1_rx_reg * s1_dy_reg;

    always_comb
    begin
        dx_w               = XW'(s2_dx_reg);
        dy_w               = XW'(s2_dy_reg);
        tok_next.first     = s2_first_reg;
        tok_next.last      = s2_last_reg;
        tok_next.ay        = s2_ay_reg;
        tok_next.by        = s2_by_reg;
        tok_next.sy        = s2_sy_reg;
        tok_next.xprod     = XW'(s2_p1_reg) - XW'(s2_p2_reg);
        tok_next.step_col  = dy_w * STEP_X_S;
        tok_next.step_wrap = dx_w * STEP_X_S + dy_w * WRAP_X_S;
        tok_next.mask      = '0;
        tok_next.count     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= edge_valid;
            s2_valid_reg  <= s1_valid_reg;
            tok_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_first_reg <= edge_req.first_edge;
            s1_last_reg  <= edge_req.last_edge;
            s1_ay_reg    <= ay_s;
            s1_by_reg    <= by_s;
            s1_sy_reg    <= sy0_s;
            s1_dx_reg    <= DW'(bx_s) - DW'(ax_s);
            s1_dy_reg    <= DW'(by_s) - DW'(ay_s);
            s1_rx_reg    <= DW'(sx0_s) - DW'(ax_s);
            s1_ry_reg    <= DW'(sy0_s) - DW'(ay_s);

            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_ay_reg    <= s1_ay_reg;
            s2_by_reg    <= s1_by_reg;
            s2_sy_reg    <= s1_sy_reg;
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_p1_reg    <= p1_next;
            s2_p2_reg    <= p2_next;

            tok_reg      <= tok_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

// File: sv/sfc_cell.sv
module sfc_cell
    import sfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   fill_rule,
    input  logic   col_wrap,
    input  logic   tok_in_valid,
    input  token_t tok_in,
    output logic   tok_out_valid,
    output token_t tok_out
);

    logic signed [COUNTER_BITS-1:0] counter_reg, counter_next;
    logic                           parity_reg, parity_next;
    logic                           tok_valid_reg;
    token_t                         tok_reg, tok_next;

    logic signed [CW-1:0]           ay, by, sy;
    logic signed [XW-1:0]           xprod;
    logic signed [COUNTER_BITS-1:0] base;
    logic                           above, up, down, covered;

    always_comb
    begin
        ay    = tok_in.ay;
        by    = tok_in.by;
        sy    = tok_in.sy;
        xprod = tok_in.xprod;

        // half-open in y, sample strictly left of the edge
        above = (ay <= sy);
        up    = above && (by > sy) && (xprod > 0);
        down  = !above && (by <= sy) && (xprod < 0);

        base        = tok_in.first ? CNT_ZERO : counter_reg;
        parity_next = (tok_in.first ? 1'b0 : parity_reg) ^ (up | down);

        if (up && base != CNT_MAX)
            counter_next = base + 1'b1;
        else if (down && base != CNT_MIN)
            counter_next = base - 1'b1;
        else
            counter_next = base;

        covered = fill_rule ? (counter_next != CNT_ZERO) : parity_next;

        tok_next       = tok_in;
        tok_next.mask  = (tok_in.mask >> 1) | (NSAMP'(covered) << (NSAMP - 1));
        tok_next.count = (covered && tok_in.count != COUNT_MAX) ?
                         tok_in.count + 1'b1 : tok_in.count;
        // move the cross product and sample row on to the next sample
        if (col_wrap)
        begin
            tok_next.xprod = xprod + tok_in.step_wrap;
            tok_next.sy    = sy + GRID_S;
        end
        else
        begin
            tok_next.xprod = xprod - tok_in.step_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= CNT_ZERO;
            parity_reg    <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tok_valid_reg <= tok_in_valid;
            if (tok_in_valid)
            begin
                counter_reg <= counter_next;
                parity_reg  <= parity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            tok_reg <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule
